// ===== rtl/kmdc_pkg.sv =====
// Shared types and constants of the keypad message display controller.
`default_nettype none

package kmdc_pkg;

    // One 7-segment pattern.
    typedef logic [6:0] code_t;

    // The four sampled column nibbles, index 0 being row 0.
    typedef logic [3:0][3:0] rows_t;

    // The pattern shown at reset and used as the message terminator.
    localparam code_t DASH_CODE = 7'd1;

    // A decode that finds no single pressed key.
    localparam code_t NO_KEY = 7'd0;

    // A nibble with no column pulled low.
    localparam logic [3:0] COLS_IDLE = 4'hF;

    // Nibbles with exactly one column pulled low.
    localparam logic [3:0] COL0_LOW = 4'hE;
    localparam logic [3:0] COL1_LOW = 4'hD;
    localparam logic [3:0] COL2_LOW = 4'hB;
    localparam logic [3:0] COL3_LOW = 4'h7;

    // Segment patterns of the keys, by row and then by column.
    localparam code_t KEY_CODES [4][4] = '{
        '{7'd48,  7'd109, 7'd121, 7'd119},
        '{7'd51,  7'd91,  7'd94,  7'd31},
        '{7'd112, 7'd127, 7'd115, 7'd78},
        '{7'd1,   7'd127, 7'd1,   7'd61}
    };

endpackage

`default_nettype wire

// ===== rtl/kmdc_key_decode.sv =====
// Keypad decoder: picks the first active row and maps its column to a pattern.
`default_nettype none

module kmdc_key_decode (
    input  wire kmdc_pkg::rows_t rows,
    output kmdc_pkg::code_t      key_code
);

    // Rows are examined from 0 upwards; the first row with a low column wins.
    always_comb begin
        logic found;
        found    = 1'b0;
        key_code = kmdc_pkg::NO_KEY;
        for (int r = 0; r < 4; r++) begin
            if (!found && rows[r] != kmdc_pkg::COLS_IDLE) begin
                found = 1'b1;
                case (rows[r])
                    kmdc_pkg::COL0_LOW: key_code = kmdc_pkg::KEY_CODES[r][0];
                    kmdc_pkg::COL1_LOW: key_code = kmdc_pkg::KEY_CODES[r][1];
                    kmdc_pkg::COL2_LOW: key_code = kmdc_pkg::KEY_CODES[r][2];
                    kmdc_pkg::COL3_LOW: key_code = kmdc_pkg::KEY_CODES[r][3];
                    // Several columns low in one row count as no key.
                    default:            key_code = kmdc_pkg::NO_KEY;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/keypad_message_display_controller.sv =====
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while m_tready does not stall the result register;
// the message store is read ahead for the next position.
// The store is a memory with one write port and one registered read port plus valid bits.
// Reset: aresetn is synchronous and active low; it empties both registers and clears
// the position, the wait flag and the valid bits, and sets the shown pattern to the dash.
`default_nettype none

module keypad_message_display_controller #(
    parameter int MESSAGE_SLOTS = 10
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // s_tdata, from bit 0: row0_cols[3:0], row1_cols[3:0], row2_cols[3:0],
    // row3_cols[3:0], next_button, tick, zero padding
    input  wire  [23:0] s_tdata,
    // s_tuser: mode
    input  wire         s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // m_tdata, from bit 0: segments[6:0], mode_led
    output logic [7:0]  m_tdata
);

    localparam int IDX_W = (MESSAGE_SLOTS > 1) ? $clog2(MESSAGE_SLOTS) : 1;
    localparam int POS_W = $clog2(MESSAGE_SLOTS + 1);
    localparam logic [POS_W-1:0] POS_END = POS_W'(MESSAGE_SLOTS);

    // Input register.
    logic            in_valid_reg;
    kmdc_pkg::rows_t in_rows_reg;
    logic            in_next_reg;
    logic            in_tick_reg;
    logic            in_mode_reg;

    // Controller state.
    logic [POS_W-1:0] position_reg, position_next;
    logic             waiting_reg, waiting_next;
    kmdc_pkg::code_t  shown_reg, shown_next;

    // Message store with its read-ahead register.
    kmdc_pkg::code_t         store_mem [MESSAGE_SLOTS];
    logic [MESSAGE_SLOTS-1:0] valid_reg;
    kmdc_pkg::code_t         rd_data_reg;
    logic                    rd_valid_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic                    rd_hit;

    // Result register.
    logic            out_valid_reg;
    kmdc_pkg::code_t out_seg_reg;
    logic            out_led_reg;

    logic            fire;
    kmdc_pkg::code_t key_code;
    kmdc_pkg::code_t slot_code;

    // The work stage moves whenever the result register is free or being emptied.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_rows_reg <= s_tdata[15:0];
            in_next_reg <= s_tdata[16];
            in_tick_reg <= s_tdata[17];
            in_mode_reg <= s_tuser;
        end
    end

    kmdc_key_decode u_decode (
        .rows     (in_rows_reg),
        .key_code (key_code)
    );

    // A slot never written plays as a blank display.
    assign slot_code = rd_valid_reg ? rd_data_reg : kmdc_pkg::NO_KEY;

    // Next state of the controller for the item in the work stage.
    always_comb begin
        position_next = position_reg;
        waiting_next  = waiting_reg;
        shown_next    = shown_reg;
        wr_en         = 1'b0;
        wr_addr       = (position_reg >= POS_END) ? '0 : position_reg[IDX_W-1:0];
        if (fire) begin
            if (waiting_reg) begin
                if (in_next_reg) begin
                    waiting_next = 1'b0;
                end
            end else if (in_mode_reg) begin
                if (key_code != kmdc_pkg::NO_KEY) begin
                    // A full buffer wraps to the first slot before storing.
                    wr_en = 1'b1;
                    if (key_code == kmdc_pkg::DASH_CODE) begin
                        position_next = '0;
                    end else begin
                        position_next = POS_W'(wr_addr) + POS_W'(1);
                        shown_next    = key_code;
                        waiting_next  = 1'b1;
                    end
                end
            end else if (in_tick_reg) begin
                if (position_reg >= POS_END) begin
                    position_next = '0;
                end else if (slot_code == kmdc_pkg::DASH_CODE) begin
                    position_next = '0;
                end else begin
                    shown_next    = slot_code;
                    position_next = position_reg + POS_W'(1);
                end
            end
        end
    end

    // The read address follows the position that the next item will see.
    assign rd_addr = (position_next >= POS_END) ? '0 : position_next[IDX_W-1:0];
    assign rd_hit  = wr_en && (wr_addr == rd_addr);

    // Store write and read-ahead, with the write forwarded on a matching address.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= key_code;
        end
        rd_data_reg <= rd_hit ? key_code : store_mem[rd_addr];
    end

    // Valid bits of the store and of the read-ahead data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= rd_hit || valid_reg[rd_addr];
        end
    end

    // Controller state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            waiting_reg  <= 1'b0;
            shown_reg    <= kmdc_pkg::DASH_CODE;
        end else begin
            position_reg <= position_next;
            waiting_reg  <= waiting_next;
            shown_reg    <= shown_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (fire) begin
            out_seg_reg <= shown_next;
            out_led_reg <= in_mode_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_led_reg, out_seg_reg};

endmodule

`default_nettype wire

// ===== rtl/kmdc_checker.sv =====
// Port-level checker of the keypad message display controller and its bind.
`default_nettype none

module kmdc_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [7:0]  m_tdata
);

    // A pattern is legal when it is blank, the dash or one of the key patterns.
    function automatic logic legal_code(kmdc_pkg::code_t code);
        logic ok;
        ok = (code == kmdc_pkg::NO_KEY) || (code == kmdc_pkg::DASH_CODE);
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (code == kmdc_pkg::KEY_CODES[r][c])
                    ok = 1'b1;
            end
        end
        return ok;
    endfunction

    // A stalled result item holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

    // Reset leaves no result item pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result item present after reset");

    // With the result side empty, the input side is always ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !m_tvalid |-> s_tready)
        else $error("input stalled while result side empty");

    // The display only ever shows blank, dash or a key pattern.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> legal_code(m_tdata[6:0]))
        else $error("unexpected segment pattern");

endmodule

bind keypad_message_display_controller kmdc_checker u_kmdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
